@@ rtl/fsdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed dead-band controller package
// Shared types, register indexes, reset values and a helper function.
// ----------------------------------------------------------------------------
package fsdc_pkg;

    // Widths fixed by the register map and the fan interface
    localparam int FAN_W    = 6;
    localparam int TARGET_W = 7;
    localparam int BAND_W   = 10;
    localparam int LIMIT_W  = 7;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int RUN_W    = 8;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_TEMP     = 2'd0,
        CFG_BAND_HALF_WIDTH = 2'd1,
        CFG_STALL_LIMIT     = 2'd2,
        CFG_START_SPEED     = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET = 7'd50;
    localparam logic [BAND_W-1:0]   BAND_RESET   = 10'd192;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd12;
    localparam logic [FAN_W-1:0]    START_RESET  = 6'd10;

    // Configuration register set
    typedef struct packed {
        logic [TARGET_W-1:0] target_temp;
        logic [BAND_W-1:0]   band_half_width;
        logic [LIMIT_W-1:0]  stall_limit;
        logic [FAN_W-1:0]    start_speed;
    } cfg_t;

    typedef logic signed [RUN_W-1:0] run_t;
    typedef logic signed [RUN_W:0]   run_sum_t;

    localparam run_t RUN_MIN = -8'sd128;
    localparam run_t RUN_MAX = 8'sd127;

    // Saturate a widened run count back into the counter range.
    function automatic run_t sat_run(input run_sum_t v);
        run_t r;
        if (v < run_sum_t'(RUN_MIN)) begin
            r = RUN_MIN;
        end
        else if (v > run_sum_t'(RUN_MAX)) begin
            r = RUN_MAX;
        end
        else begin
            r = v[RUN_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/fan_speed_deadband_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed dead-band controller
// Each accepted item is held in the input register, and its result is then
// registered in the result register.
// Throughput: one item per cycle while out_ready is high; the compare-and-step
// logic between the input register and the result register is combinational.
// Reset: configuration returns to target 50, half-width 192, stall limit 12,
// start speed 10; history and run counters clear, both registers empty.
// ----------------------------------------------------------------------------
module fan_speed_deadband_controller #(
    parameter int MAX_SPEED = 50,
    parameter int TEMP_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [fsdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsdc_pkg::CFG_W-1:0]      cfg_data,
    // Input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [TEMP_BITS-1:0]            cpu_temperature,
    input  logic [TEMP_BITS-1:0]            gpu_temperature,
    input  logic [fsdc_pkg::FAN_W-1:0]      reported_speed,
    // Result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fsdc_pkg::FAN_W-1:0]      fan_speed,
    output logic                            write_request,
    output logic                            hotter_sensor
);
    import fsdc_pkg::*;

    // Speed width, a common width for speed compares, and the signed working
    // width for temperatures against band edges (edges reach 127*256+1023).
    localparam int SPD_W = $clog2(MAX_SPEED + 1);
    localparam int LW    = (SPD_W > FAN_W) ? SPD_W : FAN_W;
    localparam int SW    = SPD_W + 2;
    localparam int CMP_W = ((TEMP_BITS > 17) ? TEMP_BITS : 17) + 2;

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.target_temp     <= TARGET_RESET;
            cfg_reg.band_half_width <= BAND_RESET;
            cfg_reg.stall_limit     <= LIMIT_RESET;
            cfg_reg.start_speed     <= START_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_TARGET_TEMP:     cfg_reg.target_temp     <= cfg_data[TARGET_W-1:0];
                CFG_BAND_HALF_WIDTH: cfg_reg.band_half_width <= cfg_data[BAND_W-1:0];
                CFG_STALL_LIMIT:     cfg_reg.stall_limit     <= cfg_data[LIMIT_W-1:0];
                CFG_START_SPEED:     cfg_reg.start_speed     <= cfg_data[FAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake between the input register and the result register
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_can_take;
    logic in_fire;
    logic advance;

    assign out_can_take = !out_valid_reg || out_ready;
    assign in_ready     = !in_valid_reg || out_can_take;
    assign in_fire      = in_valid && in_ready;
    assign advance      = in_valid_reg && out_can_take;

    // Input register
    logic [TEMP_BITS-1:0] cpu_reg;
    logic [TEMP_BITS-1:0] gpu_reg;
    logic [FAN_W-1:0]     readback_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            cpu_reg      <= cpu_temperature;
            gpu_reg      <= gpu_temperature;
            readback_reg <= reported_speed;
        end
    end

    // Controller state
    logic [TEMP_BITS-1:0] prev_cpu_reg;
    logic [TEMP_BITS-1:0] prev_gpu_reg;
    logic                 have_prev_reg;
    logic [SPD_W-1:0]     speed_reg;
    run_t                 hot_run_reg;
    run_t                 cold_run_reg;

    logic [SPD_W-1:0]     speed_next;
    run_t                 hot_run_next;
    run_t                 cold_run_next;
    logic                 write_next;
    logic                 use_gpu;

    // Sensor selection, band position and trend
    logic [TEMP_BITS-1:0]     t_sel;
    logic [TEMP_BITS-1:0]     t_old;
    logic signed [CMP_W-1:0]  t_ext;
    logic signed [CMP_W-1:0]  centre;
    logic signed [CMP_W-1:0]  floor_edge;
    logic signed [CMP_W-1:0]  ceil_edge;
    logic                     rising;
    logic                     falling;
    logic                     in_band;
    logic                     below_band;

    assign use_gpu    = gpu_reg > cpu_reg;
    assign t_sel      = use_gpu ? gpu_reg : cpu_reg;
    assign t_old      = use_gpu ? prev_gpu_reg : prev_cpu_reg;
    assign t_ext      = signed'(CMP_W'(t_sel));
    assign centre     = signed'(CMP_W'({cfg_reg.target_temp, 8'h00}));
    assign floor_edge = centre - signed'(CMP_W'(cfg_reg.band_half_width));
    assign ceil_edge  = centre + signed'(CMP_W'(cfg_reg.band_half_width));
    assign rising     = t_sel > t_old;
    assign falling    = t_sel < t_old;
    assign in_band    = (t_ext >= floor_edge) && (t_ext <= ceil_edge);
    assign below_band = t_ext < floor_edge;

    // Start speed saturated at the top speed
    logic [LW-1:0]    start_lw;
    logic [SPD_W-1:0] start_load;

    assign start_lw   = LW'(cfg_reg.start_speed);
    assign start_load = (start_lw > LW'(MAX_SPEED)) ? SPD_W'(MAX_SPEED)
                                                    : SPD_W'(start_lw);

    // Step decision, run counters and clamping
    logic signed [SW-1:0] s_work;
    run_t                 cold_upd;
    run_t                 hot_upd;
    run_t                 limit_run;

    assign limit_run = signed'(RUN_W'(cfg_reg.stall_limit));

    always_comb
    begin
        s_work        = signed'(SW'(speed_reg));
        hot_run_next  = hot_run_reg;
        cold_run_next = cold_run_reg;
        cold_upd      = cold_run_reg;
        hot_upd       = hot_run_reg;
        speed_next    = speed_reg;
        write_next    = 1'b0;

        if (!have_prev_reg) begin
            speed_next = start_load;
        end
        else begin
            if (in_band) begin
                hot_run_next  = '0;
                cold_run_next = '0;
                if (rising) begin
                    s_work = s_work + SW'(1);
                end
                else if (falling) begin
                    s_work = s_work - SW'(1);
                end
            end
            else if (below_band) begin
                if (!rising && !falling) begin
                    cold_upd = sat_run(run_sum_t'(cold_run_reg) + run_sum_t'(1));
                end
                else if (rising) begin
                    cold_upd = sat_run(run_sum_t'(cold_run_reg) - run_sum_t'(1));
                end
                cold_run_next = cold_upd;
                if (falling || (cold_upd == limit_run)) begin
                    s_work        = s_work - SW'(1);
                    cold_run_next = '0;
                end
            end
            else begin
                if (!rising && !falling) begin
                    hot_upd = sat_run(run_sum_t'(hot_run_reg) + run_sum_t'(1));
                end
                else if (falling) begin
                    hot_upd = sat_run(run_sum_t'(hot_run_reg) - run_sum_t'(1));
                end
                hot_run_next = hot_upd;
                if (rising || (hot_upd == limit_run)) begin
                    s_work       = s_work + SW'(1);
                    hot_run_next = '0;
                end
            end

            if (s_work < signed'(SW'(1))) begin
                speed_next = SPD_W'(1);
            end
            else if (s_work > signed'(SW'(MAX_SPEED))) begin
                speed_next = SPD_W'(MAX_SPEED);
            end
            else begin
                speed_next = s_work[SPD_W-1:0];
            end
            write_next = LW'(speed_next) != LW'(readback_reg);
        end
    end

    // State update as each item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_cpu_reg  <= '0;
            prev_gpu_reg  <= '0;
            have_prev_reg <= 1'b0;
            speed_reg     <= '0;
            hot_run_reg   <= '0;
            cold_run_reg  <= '0;
        end
        else if (advance) begin
            prev_cpu_reg  <= cpu_reg;
            prev_gpu_reg  <= gpu_reg;
            have_prev_reg <= 1'b1;
            speed_reg     <= speed_next;
            hot_run_reg   <= hot_run_next;
            cold_run_reg  <= cold_run_next;
        end
    end

    // Valid flags of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_fire) begin
                in_valid_reg <= 1'b1;
            end
            else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    logic [FAN_W-1:0] out_speed_reg;
    logic             out_write_reg;
    logic             out_hot_reg;

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_speed_reg <= FAN_W'(LW'(speed_next));
            out_write_reg <= write_next;
            out_hot_reg   <= use_gpu;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fan_speed     = out_speed_reg;
    assign write_request = out_write_reg;
    assign hotter_sensor = out_hot_reg;

    // The first item after reset never asks for a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !have_prev_reg) |=> !out_write_reg)
        else $error("write requested on the first item");

    // After the first item the speed is always clamped to 1..MAX_SPEED.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && have_prev_reg) |=>
            (speed_reg >= SPD_W'(1)) && (LW'(speed_reg) <= LW'(MAX_SPEED)))
        else $error("speed outside its clamp range");

    // A held item stays in the input register while the result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_can_take) |=> (in_valid_reg && $stable(cpu_reg)))
        else $error("input register lost an item while stalled");

    // History is marked present once an item has passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (have_prev_reg && out_valid_reg))
        else $error("item passed without history or result");

endmodule
